// File: sv/mskth_pkg.sv
`timescale 1ns / 1ps

package mskth_pkg;

    // Input action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam int VALUE_BITS = 10;
    localparam int RANK_BITS  = 16;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FEWER  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    // Work handed to the tree sequencer; hi_end is the clipped range end plus one.
    typedef struct packed {
        op_t                   op;
        logic [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0]  rank;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS:0]   hi_end;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] kth;
        status_t               status;
    } res_t;

endpackage

// File: sv/multiset_range_kth_smallest.sv
// Tree depth L = clog2(NUM_VALUES). Insert/remove walk the count memory from leaf to root;
// a query makes two parallel prefix walks, then one descent, one tree level a cycle on the
// count memory. Out-of-domain, empty-range and unused-action words bypass the tree.
// Throughput: one item at a time; the next word is taken once the result is registered
// and the output register is free. Reset: asynchronous, active low; then a clearing pass
// zeroes every word of the count memory with in_ready held low.
`timescale 1ns / 1ps

module multiset_range_kth_smallest #(
    parameter int NUM_VALUES = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [9:0]  item_value,
    input  logic [15:0] rank,
    input  logic [9:0]  range_low,
    input  logic [9:0]  range_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  kth_value,
    output logic [1:0]  status
);

    localparam int AW = $clog2(NUM_VALUES) + 1;
    localparam logic [16:0] NV = 17'(NUM_VALUES);

    logic                  accept;
    logic                  out_free;
    logic                  imm;
    mskth_pkg::res_t       imm_res;
    mskth_pkg::cmd_t       cmd;
    logic [9:0]            hi_clip;
    logic                  seq_idle;
    logic                  seq_done;
    mskth_pkg::res_t       seq_res;
    logic                  res_take;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [COUNT_BITS-1:0] mem_rdata_a;
    logic [COUNT_BITS-1:0] mem_rdata_b;

    logic                  out_valid_reg, out_valid_next;
    mskth_pkg::res_t       out_res_reg, out_res_next;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = seq_idle && out_free;
    assign accept   = in_valid && in_ready;
    assign res_take = seq_done && out_free;

    assign hi_clip = (17'(range_high) >= NV) ? 10'(NV - 17'd1) : range_high;

    // Settle out-of-domain and empty cases here; hand tree work to the sequencer.
    always_comb
    begin
        imm        = 1'b0;
        imm_res    = '{kth: '0, status: mskth_pkg::ST_OK};
        cmd.value  = item_value;
        cmd.rank   = rank;
        cmd.lo     = range_low;
        cmd.hi_end = {1'b0, hi_clip} + 11'd1;
        cmd.op     = mskth_pkg::OP_QUERY;
        unique case (action)
            mskth_pkg::ACT_INSERT:
            begin
                cmd.op = mskth_pkg::OP_INSERT;
                if (17'(item_value) >= NV)
                begin
                    imm            = 1'b1;
                    imm_res.status = mskth_pkg::ST_FULL;
                end
            end
            mskth_pkg::ACT_REMOVE:
            begin
                cmd.op = mskth_pkg::OP_REMOVE;
                if (17'(item_value) >= NV)
                begin
                    imm            = 1'b1;
                    imm_res.status = mskth_pkg::ST_ABSENT;
                end
            end
            mskth_pkg::ACT_QUERY:
            begin
                if (rank == '0 || range_low > hi_clip)
                begin
                    imm            = 1'b1;
                    imm_res.status = mskth_pkg::ST_FEWER;
                end
            end
            default:
            begin
                imm = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        priority if (accept && imm)
        begin
            out_valid_next = 1'b1;
            out_res_next   = imm_res;
        end
        else if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = seq_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign kth_value = out_res_reg.kth;
    assign status    = out_res_reg.status;

    mskth_seq #(
        .NUM_VALUES (NUM_VALUES),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && !imm),
        .cmd         (cmd),
        .idle        (seq_idle),
        .done        (seq_done),
        .res         (seq_res),
        .res_take    (res_take),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    mskth_ram #(
        .AW (AW),
        .DW (COUNT_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule

// File: sv/mskth_ram.sv
`timescale 1ns / 1ps

module mskth_ram #(
    parameter int AW = 11,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: sv/mskth_seq.sv
`timescale 1ns / 1ps

module mskth_seq #(
    parameter int NUM_VALUES = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mskth_pkg::cmd_t       cmd,
    output logic                  idle,
    output logic                  done,
    output mskth_pkg::res_t       res,
    input  logic                  res_take,
    output logic                  mem_we,
    output logic [$clog2(NUM_VALUES):0] mem_waddr,
    output logic [COUNT_BITS-1:0] mem_wdata,
    output logic [$clog2(NUM_VALUES):0] mem_raddr_a,
    output logic [$clog2(NUM_VALUES):0] mem_raddr_b,
    input  logic [COUNT_BITS-1:0] mem_rdata_a,
    input  logic [COUNT_BITS-1:0] mem_rdata_b
);

    localparam int L  = $clog2(NUM_VALUES);
    localparam int AW = L + 1;
    localparam int LW = (L > 1) ? $clog2(L) : 1;
    localparam int CB = COUNT_BITS;

    localparam logic [CB-1:0] CMAX      = '1;
    localparam logic [AW-1:0] ROOT      = AW'(1);
    localparam logic [AW-1:0] ROOT_LEFT = AW'(2);
    localparam logic [AW-1:0] PSIZE     = {1'b1, {L{1'b0}}};
    localparam logic [LW-1:0] LAST_LVL  = LW'(L - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_WALK,
        S_CHECK,
        S_DESC,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   node_a_reg, node_a_next;
    logic [AW-1:0]   node_b_reg, node_b_next;
    logic [L-1:0]    lo_sh_reg, lo_sh_next;
    logic [L-1:0]    end_sh_reg, end_sh_next;
    logic            end_full_reg, end_full_next;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [CB-1:0]   acc_a_reg, acc_a_next;
    logic [CB-1:0]   acc_b_reg, acc_b_next;
    logic [CB-1:0]   tgt_reg, tgt_next;
    logic [CB-1:0]   total_reg, total_next;
    logic [mskth_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic            up_reg, up_next;
    logic            first_reg, first_next;
    mskth_pkg::res_t res_reg, res_next;

    logic [AW-1:0]   leaf_addr;
    logic [AW-1:0]   end_ext;
    logic [CB-1:0]   cnt_b;
    logic [CB-1:0]   in_range;
    logic            go_left;

    assign leaf_addr = {1'b1, L'(32'(cmd.value))};
    assign end_ext   = AW'(32'(cmd.hi_end));
    assign cnt_b     = end_full_reg ? total_reg : acc_b_reg;
    assign in_range  = cnt_b - acc_a_reg;
    assign go_left   = mem_rdata_a >= tgt_reg;

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        node_a_next   = node_a_reg;
        node_b_next   = node_b_reg;
        lo_sh_next    = lo_sh_reg;
        end_sh_next   = end_sh_reg;
        end_full_next = end_full_reg;
        lvl_next      = lvl_reg;
        acc_a_next    = acc_a_reg;
        acc_b_next    = acc_b_reg;
        tgt_next      = tgt_reg;
        total_next    = total_reg;
        rank_next     = rank_reg;
        up_next       = up_reg;
        first_next    = first_reg;
        res_next      = res_reg;

        mem_we      = 1'b0;
        mem_waddr   = node_a_reg;
        mem_wdata   = up_reg ? mem_rdata_a + CB'(1) : mem_rdata_a - CB'(1);
        mem_raddr_a = {node_a_reg[AW-2:0], 1'b0};
        mem_raddr_b = {node_b_reg[AW-2:0], 1'b0};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    rank_next = cmd.rank;
                    unique case (cmd.op)
                        mskth_pkg::OP_INSERT,
                        mskth_pkg::OP_REMOVE:
                        begin
                            if (cmd.op == mskth_pkg::OP_INSERT && total_reg == CMAX)
                            begin
                                res_next   = '{kth: '0, status: mskth_pkg::ST_FULL};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                node_a_next = leaf_addr;
                                mem_raddr_a = leaf_addr;
                                up_next     = (cmd.op == mskth_pkg::OP_INSERT);
                                first_next  = 1'b1;
                                state_next  = S_UPD;
                            end
                        end
                        mskth_pkg::OP_QUERY:
                        begin
                            node_a_next   = ROOT;
                            node_b_next   = ROOT;
                            mem_raddr_a   = ROOT_LEFT;
                            mem_raddr_b   = ROOT_LEFT;
                            acc_a_next    = '0;
                            acc_b_next    = '0;
                            lvl_next      = '0;
                            lo_sh_next    = L'(32'(cmd.lo));
                            end_sh_next   = end_ext[L-1:0];
                            end_full_next = (end_ext == PSIZE);
                            state_next    = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Leaf to root: write back the count read last cycle, read the parent.
            S_UPD:
            begin
                if (!up_reg && first_reg && mem_rdata_a == '0)
                begin
                    res_next   = '{kth: '0, status: mskth_pkg::ST_ABSENT};
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    first_next = 1'b0;
                    if (node_a_reg == ROOT)
                    begin
                        total_next = up_reg ? total_reg + CB'(1) : total_reg - CB'(1);
                        res_next   = '{kth: '0, status: mskth_pkg::ST_OK};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        node_a_next = node_a_reg >> 1;
                        mem_raddr_a = node_a_reg >> 1;
                    end
                end
            end

            // Two root-to-leaf walks in parallel: counts below lo and below hi+1.
            S_WALK:
            begin
                if (lo_sh_reg[L-1])
                begin
                    acc_a_next = acc_a_reg + mem_rdata_a;
                end
                if (end_sh_reg[L-1])
                begin
                    acc_b_next = acc_b_reg + mem_rdata_b;
                end
                node_a_next = {node_a_reg[AW-2:0], lo_sh_reg[L-1]};
                node_b_next = {node_b_reg[AW-2:0], end_sh_reg[L-1]};
                mem_raddr_a = {node_a_next[AW-2:0], 1'b0};
                mem_raddr_b = {node_b_next[AW-2:0], 1'b0};
                lo_sh_next  = lo_sh_reg << 1;
                end_sh_next = end_sh_reg << 1;
                lvl_next    = lvl_reg + LW'(1);
                if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (32'(rank_reg) > 32'(in_range))
                begin
                    res_next   = '{kth: '0, status: mskth_pkg::ST_FEWER};
                    state_next = S_DONE;
                end
                else
                begin
                    // Global rank of the answer: values below lo plus k.
                    tgt_next    = acc_a_reg + CB'(32'(rank_reg));
                    node_a_next = ROOT;
                    mem_raddr_a = ROOT_LEFT;
                    lvl_next    = '0;
                    state_next  = S_DESC;
                end
            end

            S_DESC:
            begin
                node_a_next = {node_a_reg[AW-2:0], ~go_left};
                tgt_next    = go_left ? tgt_reg : tgt_reg - mem_rdata_a;
                mem_raddr_a = {node_a_next[AW-2:0], 1'b0};
                lvl_next    = lvl_reg + LW'(1);
                if (lvl_reg == LAST_LVL)
                begin
                    res_next = '{kth: mskth_pkg::VALUE_BITS'(32'(node_a_next[L-1:0])),
                                 status: mskth_pkg::ST_OK};
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            res_reg   <= '{kth: '0, status: mskth_pkg::ST_OK};
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            total_reg    <= total_next;
            res_reg      <= res_next;
            node_a_reg   <= node_a_next;
            node_b_reg   <= node_b_next;
            lo_sh_reg    <= lo_sh_next;
            end_sh_reg   <= end_sh_next;
            end_full_reg <= end_full_next;
            lvl_reg      <= lvl_next;
            acc_a_reg    <= acc_a_next;
            acc_b_reg    <= acc_b_next;
            tgt_reg      <= tgt_next;
            rank_reg     <= rank_next;
            up_reg       <= up_next;
            first_reg    <= first_next;
        end
    end

endmodule
